// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on clk and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lccp_pkg.sv -----
package lccp_pkg;

	localparam int COEFF_W = 12;
	localparam int D_W     = 4;
	localparam int VAL_W   = 11;
	localparam int QUO_W   = 12;
	localparam int NUM_W   = 24;
	localparam int RECIP_W = 25;
	localparam int PROD_W  = NUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 36;
	localparam int ACC_W   = 18;
	localparam int BUF_W   = 24;
	localparam int PEND_W  = 7;
	localparam int CNT_W   = 3;
	localparam int TOT_W   = 5;
	localparam int REM_W   = 2;

	localparam logic [D_W-1:0]     D_RESET = 4'd10;
	localparam logic [D_W-1:0]     D_MIN   = 4'd1;
	localparam logic [D_W-1:0]     D_MAX   = 4'd11;
	localparam logic [NUM_W-1:0]   HALF_Q  = 24'd1664;
	// Rounded-up reciprocal of q = 3329, scaled by 2^36.
	localparam logic [RECIP_W-1:0] RECIP_Q = 25'd20642679;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] value;
		logic [D_W-1:0]   width;
		logic             last;
	} lccp_coeff_t;

endpackage

// ----- rtl/lccp_compress.sv -----
module lccp_compress
	import lccp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [D_W-1:0]     cfg_width,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COEFF_W-1:0] coefficient,
	input  logic               last_coeff,
	output lccp_coeff_t        coeff_out,
	input  logic               coeff_stall
);

	logic               vld_s1;
	logic [COEFF_W-1:0] coef_s1;
	logic               last_s1;
	logic [D_W-1:0]     d_s1;
	logic               vld_s2;
	logic [QUO_W-1:0]   quo_s2;
	logic               last_s2;
	logic [D_W-1:0]     d_s2;
	logic [D_W-1:0]     d_eff;
	logic [NUM_W-1:0]   num;
	logic [PROD_W-1:0]  prod;
	logic [QUO_W:0]     mask;
	logic               adv2;
	logic               en1;

	always_comb begin
		if (cfg_width < D_MIN) begin
			d_eff = D_MIN;
		end else if (cfg_width > D_MAX) begin
			d_eff = D_MAX;
		end else begin
			d_eff = cfg_width;
		end
	end

	assign adv2     = !vld_s2 || !coeff_stall;
	assign en1      = !vld_s1 || adv2;
	assign in_stall = !en1;

	// Round half up of x * 2^d / q, with the division done by a reciprocal multiply.
	assign num  = ({{(NUM_W-COEFF_W){1'b0}}, coef_s1} << d_s1) + HALF_Q;
	assign prod = PROD_W'(num) * PROD_W'(RECIP_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= in_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			coef_s1 <= coefficient;
			last_s1 <= last_coeff;
			d_s1    <= d_eff;
		end
		if (adv2) begin
			quo_s2  <= prod[RECIP_SHIFT +: QUO_W];
			last_s2 <= last_s1;
			d_s2    <= d_s1;
		end
	end

	assign mask = ({{QUO_W{1'b0}}, 1'b1} << d_s2) - {{QUO_W{1'b0}}, 1'b1};

	assign coeff_out.valid = vld_s2;
	assign coeff_out.value = quo_s2[VAL_W-1:0] & mask[VAL_W-1:0];
	assign coeff_out.width = d_s2;
	assign coeff_out.last  = last_s2;

endmodule

// ----- rtl/lccp_pack.sv -----
`include "assert_macros.svh"

module lccp_pack
	import lccp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  lccp_coeff_t coeff_in,
	output logic        coeff_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  packed_byte,
	output logic        last_byte
);

	logic [PEND_W-1:0] pend_q;
	logic [CNT_W-1:0]  pend_cnt_q;
	logic [BUF_W-1:0]  buf_q;
	logic [REM_W-1:0]  rem_q;
	logic              last_q;
	logic [ACC_W-1:0]  acc;
	logic [TOT_W-1:0]  tot;
	logic [1:0]        full;
	logic [REM_W-1:0]  nbytes;
	logic [PEND_W-1:0] pend_next;
	logic [CNT_W-1:0]  cnt_next;
	logic              take;
	logic              load;

	assign acc = {{(ACC_W-PEND_W){1'b0}}, pend_q}
		| ({{(ACC_W-VAL_W){1'b0}}, coeff_in.value} << pend_cnt_q);
	assign tot  = {{(TOT_W-CNT_W){1'b0}}, pend_cnt_q} + {1'b0, coeff_in.width};
	assign full = tot[4:3];

	always_comb begin
		case (full)
			2'd0:    pend_next = acc[6:0];
			2'd1:    pend_next = acc[14:8];
			2'd2:    pend_next = {5'd0, acc[17:16]};
			default: pend_next = '0;
		endcase
		if (coeff_in.last) begin
			nbytes    = full + {1'b0, (tot[2:0] != 3'd0)};
			pend_next = '0;
			cnt_next  = '0;
		end else begin
			nbytes   = full;
			cnt_next = tot[2:0];
		end
	end

	assign take        = (rem_q != '0) && !out_stall;
	assign load        = coeff_in.valid && ((rem_q == '0) || ((rem_q == 2'd1) && take));
	assign coeff_stall = coeff_in.valid && !load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			pend_cnt_q <= '0;
			rem_q      <= '0;
			last_q     <= 1'b0;
		end else if (load) begin
			pend_q     <= pend_next;
			pend_cnt_q <= cnt_next;
			rem_q      <= nbytes;
			last_q     <= coeff_in.last;
		end else if (take) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= {{(BUF_W-ACC_W){1'b0}}, acc};
		end else if (take) begin
			buf_q <= {8'd0, buf_q[BUF_W-1:8]};
		end
	end

	assign out_valid   = rem_q != '0;
	assign packed_byte = buf_q[7:0];
	assign last_byte   = last_q && (rem_q == 2'd1);

	`ASSERT_ALWAYS(a_load_when_free, !load || (rem_q == '0) || ((rem_q == 2'd1) && take), "load over pending bytes")
	`ASSERT_NEXT(a_last_clears, load && coeff_in.last, pend_cnt_q == '0, "accumulator not empty after last")
	`ASSERT_ALWAYS(a_two_full_max, !load || coeff_in.last || (nbytes != 2'd3), "three bytes without last")

endmodule

// ----- rtl/lattice_coeff_compress_pack_unit.sv -----
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   coefficient[11:0], last_coeff
// out       output     out_valid / out_stall packed_byte[7:0], last_byte
// cfg       input      cfg_valid / cfg_ready bits_per_coeff[3:0]
//
// A coefficient passes an input register and a product register, then reaches the byte buffer.
// One coefficient is taken per cycle while in_stall is low; the output port sends one byte per
// cycle while out_stall is low, so a coefficient that yields two or three bytes holds the byte
// buffer until its last byte is taken.
// Reset clears the pipeline and the accumulator and sets the width to 10.
// An output stall holds the byte buffer and backs up through both pipeline stages.
module lattice_coeff_compress_pack_unit
	import lccp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [D_W-1:0]     bits_per_coeff,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COEFF_W-1:0] coefficient,
	input  logic               last_coeff,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         packed_byte,
	output logic               last_byte
);

	logic [D_W-1:0] width_q;
	lccp_coeff_t    coeff;
	logic           coeff_stall;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= D_RESET;
		end else if (cfg_valid && cfg_ready) begin
			width_q <= bits_per_coeff;
		end
	end

	lccp_compress u_compress (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_width   (width_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.coefficient (coefficient),
		.last_coeff  (last_coeff),
		.coeff_out   (coeff),
		.coeff_stall (coeff_stall)
	);

	lccp_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.coeff_in    (coeff),
		.coeff_stall (coeff_stall),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packed_byte (packed_byte),
		.last_byte   (last_byte)
	);

endmodule

// ----- verif/tb_lattice_coeff_compress_pack_unit.sv -----
module tb_lattice_coeff_compress_pack_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import lccp_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int PHASES        = 8;
	localparam int PHASE_COEFFS  = 63;
	localparam int MAX_SHOWN     = 40;
	localparam int unsigned COEFF_Q = 3329;

	typedef enum logic {ROW_CFG, ROW_COEFF} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [11:0] value;
		logic        last;
		int          typed_n;
		logic [23:0] bytes;
		logic [2:0]  lasts;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [D_W-1:0]     bits_per_coeff;
	logic               in_valid;
	logic               in_stall;
	logic [COEFF_W-1:0] coefficient;
	logic               last_coeff;
	logic               out_valid;
	logic               out_stall;
	logic [7:0]         packed_byte;
	logic               last_byte;

	logic [D_W-1:0] width_reg;
	logic [6:0]     pend_bits;
	int unsigned    pend_cnt;
	out_byte_t      byte_q[$];
	out_byte_t      fresh_q[$];
	int             errors = 0;
	int             shown = 0;
	int             cycles = 0;
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	bit             long_hold_req = 1'b0;

	// Rows that carry typed bytes are read straight off the packing rules; the others
	// are predicted.
	stim_row_t directed [26] = '{
		'{ROW_COEFF, 12'd0,    1'b1,  2, 24'h000000, 3'b010},
		'{ROW_COEFF, 12'd3328, 1'b1,  2, 24'h000000, 3'b010},
		'{ROW_COEFF, 12'd4095, 1'b1,  2, 24'h0000EC, 3'b010},
		'{ROW_COEFF, 12'd1664, 1'b1,  2, 24'h000200, 3'b010},
		'{ROW_CFG,   12'd8,    1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd1664, 1'b0,  1, 24'h000080, 3'b000},
		'{ROW_COEFF, 12'd3328, 1'b1,  1, 24'h000000, 3'b001},
		'{ROW_CFG,   12'd0,    1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd1664, 1'b0,  0, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd0,    1'b1,  1, 24'h000001, 3'b001},
		'{ROW_CFG,   12'd15,   1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd4095, 1'b0,  1, 24'h0000D7, 3'b000},
		'{ROW_COEFF, 12'd4095, 1'b0,  1, 24'h0000B9, 3'b000},
		'{ROW_COEFF, 12'd3328, 1'b1,  3, 24'h01FFCE, 3'b100},
		'{ROW_CFG,   12'd12,   1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd2047, 1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd3329, 1'b0, -1, 24'h000000, 3'b000},
		'{ROW_CFG,   12'd3,    1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd1,    1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd2730, 1'b1, -1, 24'h000000, 3'b000},
		'{ROW_CFG,   12'd11,   1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd1665, 1'b0, -1, 24'h000000, 3'b000},
		'{ROW_CFG,   12'd5,    1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd3000, 1'b1, -1, 24'h000000, 3'b000},
		'{ROW_CFG,   12'd1,    1'b0, -1, 24'h000000, 3'b000},
		'{ROW_COEFF, 12'd3328, 1'b1,  1, 24'h000000, 3'b001}
	};

	lattice_coeff_compress_pack_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic void pack_coeff(input logic [11:0] x, input logic last);
		int unsigned d;
		int unsigned q;
		int unsigned acc;
		int unsigned cnt;
		out_byte_t   entry;
		d = (width_reg == 0) ? int'(D_MIN) : (width_reg > D_MAX) ? int'(D_MAX) : int'(width_reg);
		q = ((int'(x) << d) + int'(HALF_Q)) / COEFF_Q;
		q = q & ((1 << d) - 1);
		acc = pend_bits | (q << pend_cnt);
		cnt = pend_cnt + d;
		fresh_q.delete();
		while (cnt >= 8) begin
			entry.data = acc[7:0];
			entry.last = 1'b0;
			fresh_q.push_back(entry);
			acc = acc >> 8;
			cnt = cnt - 8;
		end
		if (last) begin
			if (cnt > 0) begin
				entry.data = acc[7:0];
				entry.last = 1'b1;
				fresh_q.push_back(entry);
			end else if (fresh_q.size() > 0) begin
				fresh_q[fresh_q.size() - 1].last = 1'b1;
			end
			acc = 0;
			cnt = 0;
		end
		pend_bits = acc[6:0];
		pend_cnt = cnt;
	endfunction

	function automatic logic [11:0] pick_coeff();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70)
			return 12'($urandom_range(0, COEFF_Q - 1));
		else if (r < 85)
			case ($urandom_range(4))
				0: return 12'd0;
				1: return 12'd1;
				2: return 12'd1664;
				3: return 12'd1665;
				default: return 12'd3328;
			endcase
		return 12'($urandom_range(COEFF_Q, 4095));
	endfunction

	task automatic report_mismatch(input string msg);
		if (shown < MAX_SHOWN) begin
			$display("%0t mismatch: %s", $time, msg);
			shown++;
		end
		errors++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (byte_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [D_W-1:0] w);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		bits_per_coeff <= w;
		do @(posedge clk); while (!cfg_ready);
		width_reg = w;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_coeff(input logic [11:0] c, input logic l, input int typed_n,
			input logic [23:0] tbytes, input logic [2:0] tlasts);
		out_byte_t entry;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coefficient <= c;
		last_coeff <= l;
		do @(posedge clk); while (in_stall);
		pack_coeff(c, l);
		if (typed_n < 0) begin
			foreach (fresh_q[i])
				byte_q.push_back(fresh_q[i]);
		end else begin
			for (int i = 0; i < typed_n; i++) begin
				entry.data = tbytes[8*i +: 8];
				entry.last = tlasts[i];
				byte_q.push_back(entry);
			end
		end
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		out_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (byte_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h last %0b", packed_byte, last_byte));
			end else begin
				want = byte_q.pop_front();
				if (packed_byte !== want.data)
					report_mismatch($sformatf("packed_byte %02h, want %02h", packed_byte, want.data));
				if (last_byte !== want.last)
					report_mismatch($sformatf("last_byte %0b, want %0b", last_byte, want.last));
			end
		end
	end

	initial begin
		int send_pct [4];
		int recv_pct [4];
		logic [D_W-1:0] phase_width [PHASES];
		int poly_left;
		logic last;
		send_pct = '{0, 58, 0, 15};
		recv_pct = '{0, 0, 58, 15};
		phase_width = '{4'd11, 4'd1, 4'd0, 4'd15, 4'd7, 4'd4, 4'd2, 4'd6};
		phase_width[5] = D_W'($urandom_range(0, 15));
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		bits_per_coeff = D_RESET;
		in_valid = 1'b0;
		coefficient = '0;
		last_coeff = 1'b0;
		width_reg = D_RESET;
		pend_bits = '0;
		pend_cnt = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[k]) begin
			if (directed[k].kind == ROW_CFG)
				write_width(directed[k].value[D_W-1:0]);
			else
				send_coeff(directed[k].value, directed[k].last, directed[k].typed_n,
					directed[k].bytes, directed[k].lasts);
		end

		// A phase can end in the middle of a polynomial, so the next width change
		// lands on pending bits.
		poly_left = $urandom_range(1, 16);
		for (int p = 0; p < PHASES; p++) begin
			send_idle_pct = send_pct[p % 4];
			recv_stall_pct = recv_pct[p % 4];
			write_width(phase_width[p]);
			for (int n = 0; n < PHASE_COEFFS; n++) begin
				poly_left--;
				last = (poly_left == 0) || ($urandom_range(99) < 3);
				if (last)
					poly_left = $urandom_range(1, 16);
				if (p == 0 && n == 20)
					long_hold_req = 1'b1;
				send_coeff(pick_coeff(), last, -1, '0, '0);
			end
		end

		settle();
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
